[rtl/prwa_pkg.sv]
`default_nettype none
package prwa_pkg;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] key;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_ip;
    logic [15:0] found_port;
    logic [8:0]  evicted_count;
  } rsp_t;

  localparam logic [2:0] ACT_JOIN  = 3'd0;
  localparam logic [2:0] ACT_LEAVE = 3'd1;
  localparam logic [2:0] ACT_QUERY = 3'd2;
  localparam logic [2:0] ACT_PONG  = 3'd3;
  localparam logic [2:0] ACT_TICK  = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_JOIN_ERR  = 3'd1;
  localparam logic [2:0] ST_LEAVE_ERR = 3'd2;
  localparam logic [2:0] ST_QUERY_ERR = 3'd3;
  localparam logic [2:0] ST_PONG_ERR  = 3'd4;
  localparam logic [2:0] ST_CMD_ERR   = 3'd5;

  localparam logic [8:0]  COUNT_MAX     = 9'd511;
  localparam logic [30:0] TIMEOUT_RESET = 31'd30;

endpackage
`default_nettype wire

[rtl/peer_registry_with_aging.sv]
`default_nettype none
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_ready    prwa_pkg::req_t
// out_     output     out_valid/out_ready  prwa_pkg::rsp_t
// cfg_     input      APB psel/penable     timeout_ticks at address 0
//
// The engine takes each request from the queue, scans the slot RAM through its single read
// port, registers the result and then hands it over.
// A two-entry request queue lets the port accept while the engine scans.
// Reset empties the table and zeros time; timeout_ticks returns to 30.
// A held result stalls the engine; the queue then fills and drops in_ready.
module peer_registry_with_aging #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire prwa_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output prwa_pkg::rsp_t      out_data,
  input  wire logic           cfg_psel,
  input  wire logic           cfg_penable,
  input  wire logic           cfg_pwrite,
  input  wire logic [1:0]     cfg_paddr,
  input  wire logic [31:0]    cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  logic           q_valid, q_ready;
  prwa_pkg::req_t q_data;
  logic [30:0]    timeout_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {1'b0, timeout_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= prwa_pkg::TIMEOUT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      timeout_r <= cfg_pwdata[30:0];
    end
  end

  prwa_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  prwa_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk(clk), .rst_n(rst_n), .timeout_ticks(timeout_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= prwa_pkg::ST_CMD_ERR) else $error("bad status");
  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != prwa_pkg::ST_OK |-> out_data.found_ip == 32'd0)
    else $error("found_ip on error");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result moved");
endmodule
`default_nettype wire

[rtl/prwa_ram.sv]
`default_nettype none
module prwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/prwa_front.sv]
`default_nettype none
// Request queue: two-entry FIFO between the port and the table engine.
module prwa_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire prwa_pkg::req_t in_data,
  output logic                q_valid,
  input  wire logic           q_ready,
  output prwa_pkg::req_t      q_data
);
  prwa_pkg::req_t buf_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = buf_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= in_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

[rtl/prwa_back.sv]
`default_nettype none
// Table engine: scans every slot for each request (a tick evicts aged slots during the scan), then applies the update.
module prwa_back #(
  parameter int TABLE_ENTRIES = 256
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [30:0]    timeout_ticks,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire prwa_pkg::req_t q_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output prwa_pkg::rsp_t      out_data
);
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int RW = 64 + 32 + 16;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [CW-1:0] idx_r;
  logic        rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  prwa_pkg::req_t req_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [31:0] time_r;
  logic        hit_r, free_r;
  logic [AW-1:0] hit_idx_r, free_idx_r;
  logic [31:0] hit_ip_r;
  logic [15:0] hit_port_r;
  logic [8:0]  evict_r;

  logic          we_rec, we_ts;
  logic [AW-1:0] waddr_rec, waddr_ts;
  logic [RW-1:0] rec_rd;
  logic [31:0]   ts_rd, ts_wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   age;
  logic          is_hit, is_old;

  assign raddr = idx_r[AW-1:0];

  prwa_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_rec (
    .clk(clk), .we(we_rec), .waddr(waddr_rec),
    .wdata({req_r.key, req_r.peer_ip, req_r.peer_port}),
    .raddr(raddr), .rdata(rec_rd)
  );
  prwa_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_ts (
    .clk(clk), .we(we_ts), .waddr(waddr_ts), .wdata(ts_wdata),
    .raddr(raddr), .rdata(ts_rd)
  );

  assign age    = time_r - ts_rd;
  assign is_hit = rd_vld_r && valid_r[rd_idx_r] && (rec_rd[RW-1 -: 64] == req_r.key);
  assign is_old = rd_vld_r && valid_r[rd_idx_r] && (age > {1'b0, timeout_ticks});

  assign q_ready = (state_r == S_IDLE);

  // Writes happen only in the done cycle.
  always_comb begin
    we_rec    = 1'b0;
    we_ts     = 1'b0;
    waddr_rec = free_idx_r;
    waddr_ts  = free_idx_r;
    ts_wdata  = time_r;
    if (state_r == S_DONE && !out_valid) begin
      case (req_r.action)
        prwa_pkg::ACT_JOIN: begin
          we_rec = !hit_r && free_r;
          we_ts  = !hit_r && free_r;
        end
        prwa_pkg::ACT_PONG: begin
          we_ts    = hit_r;
          waddr_ts = hit_idx_r;
        end
        default: begin
          we_ts = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_SCAN;
      S_SCAN: if (rd_vld_r && rd_idx_r == AW'(TABLE_ENTRIES - 1)) state_nxt = S_DONE;
      S_DONE: if (out_valid && out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      time_r    <= '0;
      out_valid <= 1'b0;
      rd_vld_r  <= 1'b0;
      idx_r     <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          rd_vld_r <= 1'b0;
          idx_r    <= '0;
          if (q_valid) begin
            req_r   <= q_data;
            hit_r   <= 1'b0;
            free_r  <= 1'b0;
            evict_r <= '0;
            if (q_data.action == prwa_pkg::ACT_TICK) time_r <= time_r + 32'd1;
          end
        end
        S_SCAN: begin
          // Issue reads at idx_r, evaluate the previous slot.
          if (idx_r != CW'(TABLE_ENTRIES)) idx_r <= idx_r + CW'(1);
          rd_vld_r <= (idx_r != CW'(TABLE_ENTRIES));
          rd_idx_r <= raddr;
          if (rd_vld_r) begin
            if (!valid_r[rd_idx_r] && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= rd_idx_r;
            end
            if (is_hit && !hit_r) begin
              hit_r      <= 1'b1;
              hit_idx_r  <= rd_idx_r;
              hit_ip_r   <= rec_rd[47:16];
              hit_port_r <= rec_rd[15:0];
            end
            if (req_r.action == prwa_pkg::ACT_TICK && is_old) begin
              valid_r[rd_idx_r] <= 1'b0;
              if (evict_r != prwa_pkg::COUNT_MAX) evict_r <= evict_r + 9'd1;
            end
          end
        end
        S_DONE: begin
          rd_vld_r <= 1'b0;
          if (!out_valid) begin
            out_valid              <= 1'b1;
            out_data.found_ip      <= '0;
            out_data.found_port    <= '0;
            out_data.evicted_count <= '0;
            out_data.status        <= prwa_pkg::ST_OK;
            case (req_r.action)
              prwa_pkg::ACT_JOIN: begin
                if (hit_r || !free_r) out_data.status <= prwa_pkg::ST_JOIN_ERR;
                else valid_r[free_idx_r] <= 1'b1;
              end
              prwa_pkg::ACT_LEAVE: begin
                if (!hit_r) out_data.status <= prwa_pkg::ST_LEAVE_ERR;
                else valid_r[hit_idx_r] <= 1'b0;
              end
              prwa_pkg::ACT_QUERY: begin
                if (!hit_r) out_data.status <= prwa_pkg::ST_QUERY_ERR;
                else begin
                  out_data.found_ip   <= hit_ip_r;
                  out_data.found_port <= hit_port_r;
                end
              end
              prwa_pkg::ACT_PONG: begin
                if (!hit_r) out_data.status <= prwa_pkg::ST_PONG_ERR;
              end
              prwa_pkg::ACT_TICK: out_data.evicted_count <= evict_r;
              default: out_data.status <= prwa_pkg::ST_CMD_ERR;
            endcase
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        default: rd_vld_r <= 1'b0;
      endcase
    end
  end
endmodule
`default_nettype wire
